[hdl/ugrs_pkg.sv]
// Shared constants, types and helper functions for the uniform grid ray step histogram.
// Used by ugrs_arith, ugrs_cnt and uniform_grid_ray_step_histogram; depends on nothing.
package ugrs_pkg;

    // Block configuration
    localparam int MAX_STEPS    = 4096;
    localparam int NUM_OCTAVES  = 32;
    localparam int NUM_LEN_BINS = 48;
    localparam int COUNTER_BITS = 40;
    localparam int OCT_BASE     = -8;
    localparam int LEN_BASE     = -24;
    localparam int FRAC         = 24;

    // Counter layout
    localparam int IDX_RAYS   = NUM_OCTAVES;
    localparam int IDX_LEN    = 2 * NUM_OCTAVES;
    localparam int IDX_TOT    = 2 * NUM_OCTAVES + NUM_LEN_BINS;
    localparam int N_COUNTERS = IDX_TOT + 4;
    localparam int ADDR_W     = $clog2(N_COUNTERS);
    localparam int OCT_W      = $clog2(NUM_OCTAVES);
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);

    // Field widths
    localparam int COORD_W    = 48;
    localparam int DIR_W      = 26;
    localparam int LEVEL_W    = 5;
    localparam int CIDX_W     = 7;
    localparam int REQ_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_STEP_W = 13;
    localparam int OUT_CNT_W  = 40;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 56;

    // Arithmetic unit widths
    localparam int WORD_W = 64;
    localparam int DIVN_W = WORD_W + FRAC;
    localparam int ITER_W = $clog2(DIVN_W + 1);

    localparam logic signed [WORD_W-1:0] T_SAT = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic [COUNTER_BITS-1:0]  CNT_MAX = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TRACE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LO_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LO_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LO_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HI_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HI_Y  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HI_Z  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL = 3'd6;

    typedef enum logic {AR_MUL, AR_DIV} ar_op_t;

    // Command to the shared multiply/divide unit
    typedef struct packed {
        logic                start;
        ar_op_t              op;
        logic [DIVN_W-1:0]   opa;
        logic [WORD_W-1:0]   opb;
    } ar_req_t;

    // Result from the shared unit, held until the next start
    typedef struct packed {
        logic                done;
        logic [2*WORD_W-1:0] prod;
        logic [DIVN_W-1:0]   quot;
        logic [WORD_W-1:0]   rem;
    } ar_rsp_t;

    // Access to the counter store
    typedef struct packed {
        logic                    rd_en;
        logic                    wr_en;
        logic                    clear;
        logic [ADDR_W-1:0]       addr;
        logic [COUNTER_BITS-1:0] wdata;
    } cnt_req_t;

    // Position of the highest set bit, zero for zero
    function automatic logic [6:0] msb_pos(input logic [WORD_W-1:0] v);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) p = 7'(i);
        end
        return p;
    endfunction

    // Octave bin of a positive value, clamped; non-positive values land in bin 0
    function automatic logic [ADDR_W-1:0] bin_of(input logic signed [WORD_W-1:0] v,
                                                 input int base, input int n);
        int b;
        b = 0;
        if (v > 0) begin
            b = int'(msb_pos(v)) - FRAC - base;
            if (b < 0) b = 0;
            if (b >= n) b = n - 1;
        end
        return ADDR_W'(b);
    endfunction

endpackage

[hdl/ugrs_arith.sv]
// Shared iterative multiply/divide unit: shift-add multiply, restoring divide.
// One add/subtract per cycle. Depends on ugrs_pkg.
module ugrs_arith (
    input  logic              clk,
    input  logic              rst_n,
    input  ugrs_pkg::ar_req_t req,
    output ugrs_pkg::ar_rsp_t rsp
);

    localparam int W = ugrs_pkg::WORD_W;
    localparam int N = ugrs_pkg::DIVN_W;

    logic                          busy_reg;
    logic                          done_reg;
    ugrs_pkg::ar_op_t              op_reg;
    logic [ugrs_pkg::ITER_W-1:0]   iter_reg;
    logic [W-1:0]                  mcand_reg;
    logic [2*W-1:0]                acc_reg;
    logic [N-1:0]                  num_reg;
    logic [W-1:0]                  rem_reg;

    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic [W+1:0] add_res;

    // The one adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        if (op_reg == ugrs_pkg::AR_DIV)
        begin
            add_x   = {rem_reg, num_reg[N-1]};
            add_y   = {1'b0, mcand_reg};
            add_res = {1'b0, add_x} - {1'b0, add_y};
        end
        else
        begin
            add_x   = {1'b0, acc_reg[2*W-1:W]};
            add_y   = acc_reg[0] ? {1'b0, mcand_reg} : '0;
            add_res = {1'b0, add_x} + {1'b0, add_y};
        end
    end

    // Sequencing of iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ugrs_pkg::AR_MUL;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                iter_reg <= (req.op == ugrs_pkg::AR_DIV) ? ugrs_pkg::ITER_W'(N)
                                                         : ugrs_pkg::ITER_W'(W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ugrs_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            if (req.op == ugrs_pkg::AR_DIV)
            begin
                mcand_reg <= req.opb;
                num_reg   <= req.opa;
                rem_reg   <= '0;
            end
            else
            begin
                mcand_reg <= req.opa[W-1:0];
                acc_reg   <= {{W{1'b0}}, req.opb};
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == ugrs_pkg::AR_DIV)
            begin
                if (!add_res[W+1])
                begin
                    rem_reg <= add_res[W-1:0];
                    num_reg <= {num_reg[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= add_x[W-1:0];
                    num_reg <= {num_reg[N-2:0], 1'b0};
                end
            end
            else
            begin
                acc_reg <= {add_res[W:0], acc_reg[W-1:1]};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

[hdl/ugrs_cnt.sv]
// Histogram counter store: one write port, one registered read port, per-entry valid bits.
// Valid bits make reset and clear take effect at once. Depends on ugrs_pkg.
module ugrs_cnt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ugrs_pkg::cnt_req_t                req,
    output logic [ugrs_pkg::COUNTER_BITS-1:0] rd_data
);

    logic [ugrs_pkg::COUNTER_BITS-1:0] mem [ugrs_pkg::N_COUNTERS];
    logic [ugrs_pkg::N_COUNTERS-1:0]   valid_reg;
    logic [ugrs_pkg::COUNTER_BITS-1:0] data_reg;
    logic                              hit_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (req.wr_en) mem[req.addr] <= req.wdata;
        if (req.rd_en) data_reg <= mem[req.addr];
    end

    // Valid bits and read qualifier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear) valid_reg <= '0;
            else if (req.wr_en) valid_reg[req.addr] <= 1'b1;
            if (req.rd_en) hit_reg <= valid_reg[req.addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

[hdl/uniform_grid_ray_step_histogram.sv]
// Top level of the uniform grid ray step histogram: request sequencer, config registers.
// Instantiates ugrs_arith and ugrs_cnt; depends on ugrs_pkg.

// Handles one request at a time; s_tready is high only while the sequencer is idle, and
// a finished result may wait in the output register while the next request is taken.
// A trace clips against the box with two divides per axis with a nonzero direction,
// then per grid step does, per such axis, a multiply, a floor divide, a multiply and a
// boundary divide, plus one more divide when the boundary is not ahead, followed by
// loop control and counter updates. Trace time is set by the single shared
// multiply/divide unit, which retires one bit per cycle. Counter reset and clear act
// at once through per-entry valid bits; there is no clearing pass.
module uniform_grid_ray_step_histogram (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [ugrs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ugrs_pkg::COORD_W-1:0]        cfg_wdata,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // origin_x[47:0], origin_y[95:48], origin_z[143:96], dir_x[169:144],
    // dir_y[195:170], dir_z[221:196], counter_index[228:222], zero pad
    input  logic [ugrs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type[1:0]
    input  logic [ugrs_pkg::REQ_W-1:0]          s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // steps_taken[12:0], ray_missed[13], step_cap_hit[14], counter_value[54:15], zero pad
    output logic [ugrs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int W  = ugrs_pkg::WORD_W;
    localparam int CW = ugrs_pkg::COORD_W;
    localparam int DW = ugrs_pkg::DIR_W;
    localparam int AW = ugrs_pkg::ADDR_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_R_WAIT, ST_T_AX, ST_T_X, ST_T_Y, ST_H_INIT,
        ST_W_LOOP, ST_W_AX, ST_W_MUL, ST_W_FD, ST_W_BM, ST_W_TB, ST_W_TH,
        ST_W_BIN, ST_W_BIN2, ST_W_B_OCT, ST_W_B_RAY, ST_W_B_LEN, ST_W_NEXT,
        ST_W_CAP, ST_B_RD, ST_B_WR, ST_FIN
    } state_t;

    // Configuration
    logic signed [CW-1:0]             lo_reg [3];
    logic signed [CW-1:0]             hi_reg [3];
    logic [ugrs_pkg::LEVEL_W-1:0]     level_reg;

    // Sequencer and ray state
    state_t                           state_reg;
    state_t                           ret_reg;
    logic signed [CW-1:0]             org_reg [3];
    logic signed [DW-1:0]             dir_reg [3];
    logic [CW-1:0]                    h_reg [3];
    logic [1:0]                       axis_reg;
    logic signed [W-1:0]              a_reg;
    logic signed [W-1:0]              b_reg;
    logic signed [W-1:0]              t_reg;
    logic signed [W-1:0]              te_reg;
    logic signed [W-1:0]              x_reg;
    logic signed [W-1:0]              mid_reg;
    logic signed [W-1:0]              span_reg;
    logic                             neg_reg;
    logic [ugrs_pkg::STEP_W-1:0]      steps_reg;
    logic [ugrs_pkg::NUM_OCTAVES-1:0] seen_reg;
    logic [ugrs_pkg::OCT_W-1:0]       oct_reg;
    logic [AW-1:0]                    len_reg;
    logic [AW-1:0]                    bump_reg;
    logic                             rd_ok_reg;
    logic                             miss_reg;
    logic                             cap_reg;
    logic [ugrs_pkg::OUT_CNT_W-1:0]   value_reg;
    ugrs_pkg::ar_req_t                ar_req_reg;

    // Output register
    logic                             m_tvalid_reg;
    logic [ugrs_pkg::OUT_STEP_W-1:0]  out_steps_reg;
    logic                             out_miss_reg;
    logic                             out_cap_reg;
    logic [ugrs_pkg::OUT_CNT_W-1:0]   out_value_reg;

    // Interconnect
    ugrs_pkg::ar_rsp_t                ar_rsp;
    ugrs_pkg::cnt_req_t               cnt_req;
    logic [ugrs_pkg::COUNTER_BITS-1:0] cnt_rd_data;
    logic [ugrs_pkg::COUNTER_BITS-1:0] cnt_inc;

    // Input fields
    logic                             accept;
    logic [ugrs_pkg::REQ_W-1:0]       in_req;
    logic [ugrs_pkg::CIDX_W-1:0]      in_cidx;
    logic                             in_cidx_ok;

    // Datapath helpers
    logic signed [W-1:0]              cur_org;
    logic signed [W-1:0]              cur_d;
    logic signed [W-1:0]              cur_lo;
    logic signed [W-1:0]              cur_hi;
    logic signed [W-1:0]              cur_h;
    logic [W-1:0]                     qd_mag;
    logic signed [W-1:0]              qd_val;
    logic signed [W-1:0]              slab_min;
    logic signed [W-1:0]              slab_max;
    logic signed [W-1:0]              slab_a;
    logic signed [W-1:0]              slab_b;
    logic signed [W-1:0]              mul_q;
    logic signed [W-1:0]              mul_n;
    logic signed [W-1:0]              fd_g;
    logic signed [W-1:0]              fd_g2;
    logic signed [W-1:0]              bm_num;
    logic signed [W-1:0]              th_tb;
    logic [W-1:0]                     mid_sum;
    logic signed [CW:0]               h_diff [3];
    logic [CW-1:0]                    h_new [3];

    // Magnitude of a signed word
    function automatic logic [W-1:0] mag64(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    // Fixed-point quotient command: |num| * 2^FRAC / |den|
    function automatic ugrs_pkg::ar_req_t qdiv_cmd(input logic signed [W-1:0] num,
                                                   input logic signed [W-1:0] den);
        ugrs_pkg::ar_req_t r;
        r.start = 1'b1;
        r.op    = ugrs_pkg::AR_DIV;
        r.opa   = {mag64(num), {ugrs_pkg::FRAC{1'b0}}};
        r.opb   = mag64(den);
        return r;
    endfunction

    // Plain unsigned multiply or divide command
    function automatic ugrs_pkg::ar_req_t plain_cmd(input ugrs_pkg::ar_op_t op,
                                                    input logic [W-1:0] x,
                                                    input logic [W-1:0] y);
        ugrs_pkg::ar_req_t r;
        r.start = 1'b1;
        r.op    = op;
        r.opa   = {{ugrs_pkg::FRAC{1'b0}}, x};
        r.opb   = y;
        return r;
    endfunction

    ugrs_arith u_arith (
        .clk (clk),
        .rst_n (rst_n),
        .req (ar_req_reg),
        .rsp (ar_rsp)
    );

    ugrs_cnt u_cnt (
        .clk (clk),
        .rst_n (rst_n),
        .req (cnt_req),
        .rd_data (cnt_rd_data)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_req     = s_tuser;
    assign in_cidx    = s_tdata[228:222];
    assign in_cidx_ok = (32'(in_cidx) < 32'(ugrs_pkg::N_COUNTERS));
    assign cnt_inc    = (cnt_rd_data == ugrs_pkg::CNT_MAX) ? cnt_rd_data
                        : cnt_rd_data + ugrs_pkg::COUNTER_BITS'(1);

    // Counter store access
    always_comb
    begin
        cnt_req.rd_en = (state_reg == ST_B_RD) ||
                        (accept && in_req == ugrs_pkg::REQ_READ && in_cidx_ok);
        cnt_req.wr_en = (state_reg == ST_B_WR);
        cnt_req.clear = accept && in_req == ugrs_pkg::REQ_CLEAR;
        cnt_req.addr  = (state_reg == ST_IDLE) ? AW'(in_cidx) : bump_reg;
        cnt_req.wdata = cnt_inc;
    end

    // Per-axis operands and post-processing of unit results
    always_comb
    begin
        cur_org  = W'(org_reg[axis_reg]);
        cur_d    = W'(dir_reg[axis_reg]);
        cur_lo   = W'(lo_reg[axis_reg]);
        cur_hi   = W'(hi_reg[axis_reg]);
        cur_h    = signed'({{(W-CW){1'b0}}, h_reg[axis_reg]});

        // saturated signed quotient
        qd_mag   = (|ar_rsp.quot[ugrs_pkg::DIVN_W-1:CW-1]) ? W'(ugrs_pkg::T_SAT)
                   : W'(ar_rsp.quot[CW-2:0]);
        qd_val   = neg_reg ? -signed'(qd_mag) : signed'(qd_mag);

        // slab interval update
        slab_min = (x_reg > qd_val) ? qd_val : x_reg;
        slab_max = (x_reg > qd_val) ? x_reg : qd_val;
        slab_a   = (slab_min > a_reg) ? slab_min : a_reg;
        slab_b   = (slab_max < b_reg) ? slab_max : b_reg;

        // position along the ray, then offset into the grid
        mul_q    = signed'(ar_rsp.prod[ugrs_pkg::DIVN_W-1:ugrs_pkg::FRAC]);
        mul_n    = cur_org + (neg_reg ? -mul_q : mul_q) - cur_lo;

        // floor quotient gives the cell index
        fd_g     = neg_reg ? -signed'(ar_rsp.quot[W-1:0]) - W'(ar_rsp.rem != '0)
                   : signed'(ar_rsp.quot[W-1:0]);
        fd_g2    = (cur_d > 0) ? fd_g + W'(1) : fd_g;

        bm_num   = cur_lo + signed'(ar_rsp.prod[W-1:0]) - cur_org;
        th_tb    = t_reg + qd_val;
        mid_sum  = W'(t_reg) + W'(te_reg);
    end

    // Cell size per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            h_diff[i] = (CW+1)'(hi_reg[i]) - (CW+1)'(lo_reg[i]);
            h_new[i]  = (h_diff[i] > 0) ? (h_diff[i][CW-1:0] >> level_reg) : '0;
            if (h_new[i] == '0) h_new[i] = CW'(1);
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= CW'(1) <<< ugrs_pkg::FRAC;
            end
            level_reg     <= ugrs_pkg::LEVEL_W'(8);
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            ar_req_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            steps_reg     <= '0;
            seen_reg      <= '0;
            axis_reg      <= '0;
            miss_reg      <= 1'b0;
            cap_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            ar_req_reg.start <= 1'b0;

            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ugrs_pkg::REG_LO_X:  lo_reg[0] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_LO_Y:  lo_reg[1] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_LO_Z:  lo_reg[2] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_HI_X:  hi_reg[0] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_HI_Y:  hi_reg[1] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_HI_Z:  hi_reg[2] <= signed'(cfg_wdata);
                    ugrs_pkg::REG_LEVEL: level_reg <= cfg_wdata[ugrs_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // result handed off
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        steps_reg <= '0;
                        miss_reg  <= 1'b0;
                        cap_reg   <= 1'b0;
                        value_reg <= '0;
                        org_reg[0] <= signed'(s_tdata[47:0]);
                        org_reg[1] <= signed'(s_tdata[95:48]);
                        org_reg[2] <= signed'(s_tdata[143:96]);
                        dir_reg[0] <= signed'(s_tdata[169:144]);
                        dir_reg[1] <= signed'(s_tdata[195:170]);
                        dir_reg[2] <= signed'(s_tdata[221:196]);
                        rd_ok_reg  <= in_cidx_ok;
                        axis_reg   <= '0;
                        a_reg      <= '0;
                        b_reg      <= ugrs_pkg::T_SAT;
                        if (in_req == ugrs_pkg::REQ_TRACE) state_reg <= ST_T_AX;
                        else if (in_req == ugrs_pkg::REQ_READ) state_reg <= ST_R_WAIT;
                        else state_reg <= ST_FIN;
                    end
                end

                ST_R_WAIT:
                begin
                    value_reg <= rd_ok_reg ? ugrs_pkg::OUT_CNT_W'(cnt_rd_data) : '0;
                    state_reg <= ST_FIN;
                end

                // box clip, one axis at a time
                ST_T_AX:
                begin
                    if (cur_d == '0)
                    begin
                        if (cur_org < cur_lo || cur_org >= cur_hi)
                        begin
                            miss_reg  <= 1'b1;
                            bump_reg  <= AW'(ugrs_pkg::IDX_TOT + 1);
                            ret_reg   <= ST_FIN;
                            state_reg <= ST_B_RD;
                        end
                        else if (axis_reg == 2'd2)
                        begin
                            bump_reg  <= AW'(ugrs_pkg::IDX_TOT);
                            ret_reg   <= ST_H_INIT;
                            state_reg <= ST_B_RD;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ar_req_reg <= qdiv_cmd(cur_lo - cur_org, cur_d);
                        neg_reg    <= (cur_lo - cur_org < 0) != (cur_d < 0);
                        state_reg  <= ST_T_X;
                    end
                end

                ST_T_X:
                begin
                    if (ar_rsp.done)
                    begin
                        x_reg      <= qd_val;
                        ar_req_reg <= qdiv_cmd(cur_hi - cur_org, cur_d);
                        neg_reg    <= (cur_hi - cur_org < 0) != (cur_d < 0);
                        state_reg  <= ST_T_Y;
                    end
                end

                ST_T_Y:
                begin
                    if (ar_rsp.done)
                    begin
                        a_reg <= slab_a;
                        b_reg <= slab_b;
                        if (slab_a > slab_b)
                        begin
                            miss_reg  <= 1'b1;
                            bump_reg  <= AW'(ugrs_pkg::IDX_TOT + 1);
                            ret_reg   <= ST_FIN;
                            state_reg <= ST_B_RD;
                        end
                        else if (axis_reg == 2'd2)
                        begin
                            bump_reg  <= AW'(ugrs_pkg::IDX_TOT);
                            ret_reg   <= ST_H_INIT;
                            state_reg <= ST_B_RD;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_T_AX;
                        end
                    end
                end

                ST_H_INIT:
                begin
                    for (int i = 0; i < 3; i++) h_reg[i] <= h_new[i];
                    seen_reg  <= '0;
                    t_reg     <= a_reg;
                    steps_reg <= '0;
                    state_reg <= ST_W_LOOP;
                end

                // grid walk
                ST_W_LOOP:
                begin
                    if (t_reg < b_reg && steps_reg < ugrs_pkg::STEP_W'(ugrs_pkg::MAX_STEPS))
                    begin
                        te_reg    <= b_reg;
                        axis_reg  <= '0;
                        state_reg <= ST_W_AX;
                    end
                    else
                    begin
                        state_reg <= ST_W_CAP;
                    end
                end

                ST_W_AX:
                begin
                    if (cur_d == '0)
                    begin
                        if (axis_reg == 2'd2) state_reg <= ST_W_BIN;
                        else axis_reg <= axis_reg + 2'd1;
                    end
                    else
                    begin
                        ar_req_reg <= plain_cmd(ugrs_pkg::AR_MUL, mag64(t_reg), mag64(cur_d));
                        neg_reg    <= (t_reg < 0) != (cur_d < 0);
                        state_reg  <= ST_W_MUL;
                    end
                end

                ST_W_MUL:
                begin
                    if (ar_rsp.done)
                    begin
                        ar_req_reg <= plain_cmd(ugrs_pkg::AR_DIV, mag64(mul_n), cur_h);
                        neg_reg    <= (mul_n < 0);
                        state_reg  <= ST_W_FD;
                    end
                end

                ST_W_FD:
                begin
                    if (ar_rsp.done)
                    begin
                        ar_req_reg <= plain_cmd(ugrs_pkg::AR_MUL, W'(fd_g2), cur_h);
                        state_reg  <= ST_W_BM;
                    end
                end

                ST_W_BM:
                begin
                    if (ar_rsp.done)
                    begin
                        ar_req_reg <= qdiv_cmd(bm_num, cur_d);
                        neg_reg    <= (bm_num < 0) != (cur_d < 0);
                        state_reg  <= ST_W_TB;
                    end
                end

                ST_W_TB:
                begin
                    if (ar_rsp.done)
                    begin
                        if (!(qd_val > t_reg))
                        begin
                            // boundary behind: step a whole cell instead
                            ar_req_reg <= qdiv_cmd(cur_h, cur_d);
                            neg_reg    <= 1'b0;
                            state_reg  <= ST_W_TH;
                        end
                        else
                        begin
                            if (qd_val < te_reg) te_reg <= qd_val;
                            if (axis_reg == 2'd2) state_reg <= ST_W_BIN;
                            else
                            begin
                                axis_reg  <= axis_reg + 2'd1;
                                state_reg <= ST_W_AX;
                            end
                        end
                    end
                end

                ST_W_TH:
                begin
                    if (ar_rsp.done)
                    begin
                        if (th_tb < te_reg) te_reg <= th_tb;
                        if (axis_reg == 2'd2) state_reg <= ST_W_BIN;
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_W_AX;
                        end
                    end
                end

                ST_W_BIN:
                begin
                    mid_reg   <= signed'(mid_sum >> 1);
                    span_reg  <= te_reg - t_reg;
                    state_reg <= ST_W_BIN2;
                end

                ST_W_BIN2:
                begin
                    oct_reg   <= ugrs_pkg::OCT_W'(ugrs_pkg::bin_of(mid_reg, ugrs_pkg::OCT_BASE,
                                                                   ugrs_pkg::NUM_OCTAVES));
                    len_reg   <= AW'(ugrs_pkg::IDX_LEN) + ugrs_pkg::bin_of(span_reg,
                                     ugrs_pkg::LEN_BASE, ugrs_pkg::NUM_LEN_BINS);
                    bump_reg  <= AW'(ugrs_pkg::IDX_TOT + 2);
                    ret_reg   <= ST_W_B_OCT;
                    state_reg <= ST_B_RD;
                end

                ST_W_B_OCT:
                begin
                    bump_reg  <= AW'(oct_reg);
                    ret_reg   <= ST_W_B_RAY;
                    state_reg <= ST_B_RD;
                end

                ST_W_B_RAY:
                begin
                    if (!seen_reg[oct_reg])
                    begin
                        seen_reg[oct_reg] <= 1'b1;
                        bump_reg  <= AW'(ugrs_pkg::IDX_RAYS) + AW'(oct_reg);
                        ret_reg   <= ST_W_B_LEN;
                        state_reg <= ST_B_RD;
                    end
                    else
                    begin
                        state_reg <= ST_W_B_LEN;
                    end
                end

                ST_W_B_LEN:
                begin
                    bump_reg  <= len_reg;
                    ret_reg   <= ST_W_NEXT;
                    state_reg <= ST_B_RD;
                end

                ST_W_NEXT:
                begin
                    t_reg     <= te_reg;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= ST_W_LOOP;
                end

                ST_W_CAP:
                begin
                    if (steps_reg >= ugrs_pkg::STEP_W'(ugrs_pkg::MAX_STEPS))
                    begin
                        cap_reg   <= 1'b1;
                        bump_reg  <= AW'(ugrs_pkg::IDX_TOT + 3);
                        ret_reg   <= ST_FIN;
                        state_reg <= ST_B_RD;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end

                // saturating counter increment, read then write
                ST_B_RD: state_reg <= ST_B_WR;
                ST_B_WR: state_reg <= ret_reg;

                ST_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_steps_reg <= ugrs_pkg::OUT_STEP_W'(steps_reg);
                        out_miss_reg  <= miss_reg;
                        out_cap_reg   <= cap_reg;
                        out_value_reg <= value_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_value_reg, out_cap_reg, out_miss_reg, out_steps_reg};

`ifndef NO_ASSERTIONS
    // a transfer in always leaves the sequencer busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("s_tready stayed high after a request transfer");

    // step count never passes the limit
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= ugrs_pkg::STEP_W'(ugrs_pkg::MAX_STEPS))
        else $error("step count exceeded limit");

    // a missed ray reports no steps and no cap
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_miss_reg |-> out_steps_reg == '0 && !out_cap_reg)
        else $error("missed ray carries steps or cap");

    // unit results only arrive while the sequencer waits for them
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        ar_rsp.done |-> (state_reg == ST_T_X || state_reg == ST_T_Y ||
                         state_reg == ST_W_MUL || state_reg == ST_W_FD ||
                         state_reg == ST_W_BM || state_reg == ST_W_TB ||
                         state_reg == ST_W_TH))
        else $error("arithmetic result arrived outside a wait state");
`endif

endmodule

[tb/tb_uniform_grid_ray_step_histogram.sv]
// Self-checking testbench for uniform_grid_ray_step_histogram: ray, read and clear requests.
// Holds its own grid traversal predictor and checks every result; depends on ugrs_pkg.
module tb_uniform_grid_ray_step_histogram;
    import ugrs_pkg::*;

    localparam longint ONE      = 64'sd1 << 24;
    localparam longint TMAX     = 64'sh7FFF_FFFF_FFFF;
    localparam longint CMAX     = (64'sd1 << COUNTER_BITS) - 1;
    localparam int     WDOG_MAX = 4000000;
    localparam int     HOLD_LEN = 600;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic signed [COORD_W-1:0] ox, oy, oz;
        logic signed [DIR_W-1:0]   dx, dy, dz;
        logic [CIDX_W-1:0]         idx;
    } ray_req_t;

    typedef struct {
        logic [OUT_STEP_W-1:0] steps;
        logic                  missed;
        logic                  capped;
        logic [OUT_CNT_W-1:0]  value;
    } ray_res_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [COORD_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    uniform_grid_ray_step_histogram dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state: grid registers and histogram counters
    longint          grid_lo[3];
    longint          grid_hi[3];
    int              grid_lvl;
    longint unsigned hist[N_COUNTERS];

    ray_req_t pending_reqs[$];
    ray_res_t expected_results[$];
    ray_req_t tx_cur;
    int       tx_gap;
    int       rx_wait;
    int       hold_cnt;
    int       hold_go = 0;
    int       hold_seen;
    bit       idle_on = 1'b1;
    int       errors = 0;
    int       quiet_cycles;

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // num * 2^24 / den, truncated toward zero, saturated
    function automatic longint fx_div(longint num, longint den);
        longint unsigned un, ud, q, m;
        un = mag64(num);
        ud = mag64(den);
        q  = un / ud;
        if (q >= (64'd1 << 23)) m = TMAX;
        else m = (q << 24) + ((un % ud) << 24) / ud;
        if (m > TMAX) m = TMAX;
        return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(longint t, longint d);
        longint unsigned ut, ud, m;
        ut = mag64(t);
        ud = mag64(d);
        m  = (ut >> 24) * ud + (((ut & 64'hFF_FFFF) * ud) >> 24);
        return ((t < 0) != (d < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint cell_floor(longint n, longint h);
        longint q;
        q = n / h;
        if (n % h != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic int octave_bin(longint v, int base, int n);
        int b;
        int p;
        if (v <= 0) return 0;
        p = 63;
        while (!v[p]) p--;
        b = p - 24 - base;
        if (b < 0) b = 0;
        if (b >= n) b = n - 1;
        return b;
    endfunction

    function automatic void hist_bump(int i);
        if (hist[i] < CMAX) hist[i]++;
    endfunction

    function automatic ray_res_t predict_histogram(ray_req_t r);
        ray_res_t res;
        longint   o[3], d[3], h[3];
        longint   a, b, t, te, x, y, g, bnd, tb, diff;
        longint unsigned seen;
        int       steps, ob;
        bit       ok;
        res = '{default: '0};
        if (r.kind == REQ_CLEAR) begin
            foreach (hist[i]) hist[i] = 0;
            return res;
        end
        if (r.kind == REQ_READ) begin
            if (r.idx < N_COUNTERS) res.value = hist[r.idx][OUT_CNT_W-1:0];
            return res;
        end
        if (r.kind != REQ_TRACE) return res;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        a = 0;
        b = TMAX;
        ok = 1'b1;
        // slab clip against the grid box
        for (int c = 0; c < 3 && ok; c++) begin
            if (d[c] == 0) begin
                if (o[c] < grid_lo[c] || !(o[c] < grid_hi[c])) ok = 1'b0;
                continue;
            end
            x = fx_div(grid_lo[c] - o[c], d[c]);
            y = fx_div(grid_hi[c] - o[c], d[c]);
            if (x > y) begin
                t = x; x = y; y = t;
            end
            if (x > a) a = x;
            if (y < b) b = y;
            if (a > b) ok = 1'b0;
        end
        if (!ok) begin
            hist_bump(IDX_TOT + 1);
            res.missed = 1'b1;
            return res;
        end
        hist_bump(IDX_TOT);
        for (int c = 0; c < 3; c++) begin
            diff = grid_hi[c] - grid_lo[c];
            h[c] = diff > 0 ? longint'(longint'(diff) >>> grid_lvl) : 0;
            if (h[c] <= 0) h[c] = 1;
        end
        // walk cell by cell
        seen = 0;
        steps = 0;
        t = a;
        while (t < b && steps < MAX_STEPS) begin
            te = b;
            for (int c = 0; c < 3; c++) begin
                if (d[c] == 0) continue;
                x   = o[c] + fx_mul(t, d[c]);
                g   = cell_floor(x - grid_lo[c], h[c]);
                bnd = grid_lo[c] + (d[c] > 0 ? g + 1 : g) * h[c];
                tb  = fx_div(bnd - o[c], d[c]);
                if (!(tb > t)) tb = t + fx_div(h[c], d[c] < 0 ? -d[c] : d[c]);
                if (tb < te) te = tb;
            end
            ob = octave_bin(longint'((longint'(t) + longint'(te)) >>> 1), OCT_BASE, NUM_OCTAVES);
            hist_bump(IDX_TOT + 2);
            hist_bump(ob);
            if (!seen[ob]) begin
                seen[ob] = 1'b1;
                hist_bump(IDX_RAYS + ob);
            end
            hist_bump(IDX_LEN + octave_bin(te - t, LEN_BASE, NUM_LEN_BINS));
            t = te;
            steps++;
        end
        if (steps >= MAX_STEPS) begin
            hist_bump(IDX_TOT + 3);
            res.capped = 1'b1;
        end
        res.steps = OUT_STEP_W'(steps);
        return res;
    endfunction

    // ---------------- request driver ----------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_histogram(tx_cur));
                tx_gap = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    tx_cur = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_cur.kind;
                    s_tdata  <= {3'b000, tx_cur.idx, tx_cur.dz, tx_cur.dy, tx_cur.dx,
                                 tx_cur.oz, tx_cur.oy, tx_cur.ox};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge clk or negedge rst_n) begin
        ray_res_t exp_r;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_cnt = 0;
            hold_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing pending, got %h", $time, m_tdata);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[12:0] !== exp_r.steps) begin
                        $display("%0t: steps_taken expected %0d got %0d",
                                 $time, exp_r.steps, m_tdata[12:0]);
                        errors++;
                    end
                    if (m_tdata[13] !== exp_r.missed) begin
                        $display("%0t: ray_missed expected %0d got %0d",
                                 $time, exp_r.missed, m_tdata[13]);
                        errors++;
                    end
                    if (m_tdata[14] !== exp_r.capped) begin
                        $display("%0t: step_cap_hit expected %0d got %0d",
                                 $time, exp_r.capped, m_tdata[14]);
                        errors++;
                    end
                    if (m_tdata[54:15] !== exp_r.value) begin
                        $display("%0t: counter_value expected %0d got %0d",
                                 $time, exp_r.value, m_tdata[54:15]);
                        errors++;
                    end
                end
                rx_wait = idle_on ? $urandom_range(0, 7) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            // long back-pressure stretch on request
            if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_cnt = HOLD_LEN;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
            end
            m_tready <= (rx_wait == 0 && hold_cnt == 0);
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > WDOG_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic longint unsigned rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic ray_req_t mk_ray(longint ox, longint oy, longint oz,
                                        longint dx, longint dy, longint dz);
        ray_req_t r;
        r.kind = REQ_TRACE;
        r.ox = ox[COORD_W-1:0]; r.oy = oy[COORD_W-1:0]; r.oz = oz[COORD_W-1:0];
        r.dx = dx[DIR_W-1:0];   r.dy = dy[DIR_W-1:0];   r.dz = dz[DIR_W-1:0];
        r.idx = CIDX_W'($urandom);
        return r;
    endfunction

    function automatic ray_req_t mk_cmd(logic [REQ_W-1:0] kind, int idx);
        ray_req_t r;
        r = mk_ray(longint'(rnd64()), longint'(rnd64()), longint'(rnd64()),
                   $urandom, $urandom, $urandom);
        r.kind = kind;
        r.idx = CIDX_W'(idx);
        return r;
    endfunction

    function automatic longint rnd_dir();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return 0;
        if (sel == 2) return ONE;
        if (sel == 3) return -ONE;
        return longint'($urandom_range(0, 1 << 25)) - ONE;
    endfunction

    // Origin near the box on one axis, or anywhere when full is set
    function automatic longint rnd_origin(int c, bit full);
        longint span;
        if (full) return longint'(rnd64() << 16) >>> 16;
        span = grid_hi[c] - grid_lo[c];
        return grid_lo[c] - span / 2 + longint'(rnd64() % longint'(2 * span + 1));
    endfunction

    task automatic push_random(int count, bit full);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                pending_reqs.push_back(mk_ray(rnd_origin(0, full), rnd_origin(1, full),
                                              rnd_origin(2, full),
                                              rnd_dir(), rnd_dir(), rnd_dir()));
            else if (sel < 95)
                pending_reqs.push_back(mk_cmd(REQ_READ, $urandom_range(0, 127)));
            else if (sel < 98)
                pending_reqs.push_back(mk_cmd(REQ_CLEAR, $urandom_range(0, 127)));
            else
                pending_reqs.push_back(mk_cmd(2'd3, $urandom_range(0, 127)));
        end
    endtask

    // Wait until every request is taken and every result checked
    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] a, longint v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v[COORD_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (a)
            REG_LO_X:  grid_lo[0] = v;
            REG_LO_Y:  grid_lo[1] = v;
            REG_LO_Z:  grid_lo[2] = v;
            REG_HI_X:  grid_hi[0] = v;
            REG_HI_Y:  grid_hi[1] = v;
            REG_HI_Z:  grid_hi[2] = v;
            REG_LEVEL: grid_lvl = int'(v[LEVEL_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_grid(longint lx, longint ly, longint lz,
                            longint hx, longint hy, longint hz, int lvl);
        cfg_write(REG_LO_X, lx);
        cfg_write(REG_LO_Y, ly);
        cfg_write(REG_LO_Z, lz);
        cfg_write(REG_HI_X, hx);
        cfg_write(REG_HI_Y, hy);
        cfg_write(REG_HI_Z, hz);
        cfg_write(REG_LEVEL, lvl);
    endtask

    initial begin
        grid_lo = '{0, 0, 0};
        grid_hi = '{ONE, ONE, ONE};
        grid_lvl = 8;
        foreach (hist[i]) hist[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: cheap requests only
        pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT));
        pending_reqs.push_back(mk_cmd(2'd3, 5));
        pending_reqs.push_back(mk_ray(-5 * ONE, ONE / 2, ONE / 2, 0, 0, 0));
        pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT + 1));
        pending_reqs.push_back(mk_cmd(REQ_CLEAR, 0));
        drain();

        // Directed rays in a unit box with two cells per axis
        set_grid(0, 0, 0, ONE, ONE, ONE, 1);
        pending_reqs.push_back(mk_ray(0, ONE / 4, ONE / 4, ONE, 0, 0));
        pending_reqs.push_back(mk_ray(ONE / 2, ONE * 9 / 10, ONE / 2, 0, -ONE, 0));
        pending_reqs.push_back(mk_ray(-ONE, -ONE, -ONE, 9686330, 9686330, 9686330));
        pending_reqs.push_back(mk_ray(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0));     // no direction
        pending_reqs.push_back(mk_ray(ONE / 2, ONE, ONE / 2, ONE, 0, 0));       // on hi: miss
        pending_reqs.push_back(mk_ray(ONE / 2, 0, ONE / 2, ONE, 0, 0));         // on lo: hit
        pending_reqs.push_back(mk_ray(ONE, ONE / 2, ONE / 2, ONE, 0, 0));       // entry = exit
        pending_reqs.push_back(mk_ray(ONE / 2, ONE / 3, ONE / 3, -ONE, 0, 0));  // on boundary
        pending_reqs.push_back(mk_ray(2 * ONE, ONE / 2, ONE / 2, ONE, 0, 0));   // points away
        pending_reqs.push_back(mk_ray(TMAX, -TMAX - 1, TMAX, -ONE, ONE, -1));
        pending_reqs.push_back(mk_ray(-TMAX - 1, ONE / 2, ONE / 2, ONE, 0, 0));
        pending_reqs.push_back(mk_cmd(2'd3, 0));
        pending_reqs.push_back(mk_cmd(REQ_READ, 0));
        pending_reqs.push_back(mk_cmd(REQ_READ, 127));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT + i));
        pending_reqs.push_back(mk_cmd(REQ_CLEAR, 3));
        pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT + 2));
        drain();

        // Hold the result side while requests keep coming
        @(negedge clk);
        hold_go++;
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(mk_cmd(REQ_READ, $urandom_range(0, 127)));
        push_random(20, 1'b0);
        drain();

        // Level 20, one ray reaching the step limit
        set_grid(0, 0, 0, ONE, ONE, ONE, 20);
        pending_reqs.push_back(mk_ray(0, ONE / 2, ONE / 2, ONE, 0, 0));
        pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT + 3));
        pending_reqs.push_back(mk_cmd(REQ_READ, IDX_TOT + 2));
        drain();

        // Degenerate cells: tiny box at level 20
        set_grid(-4, 3, -8, 4, 11, 0, 20);
        push_random(300, 1'b0);
        drain();

        // Widest box, single cell, origins anywhere
        set_grid(-TMAX - 1, -TMAX - 1, -TMAX - 1, TMAX, TMAX, TMAX, 0);
        push_random(250, 1'b1);
        drain();

        idle_on = 1'b0;
        set_grid(-7 * ONE / 2, -ONE / 4, 2 * ONE, -ONE, 7 * ONE / 4, 5 * ONE / 2, 2);
        push_random(250, 1'b0);
        drain();

        idle_on = 1'b1;
        set_grid(0, 0, 0, ONE, ONE, ONE, 2);
        push_random(400, 1'b0);
        drain();

        set_grid(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1);
        push_random(360, 1'b0);
        for (int i = 0; i < N_COUNTERS; i += 7) pending_reqs.push_back(mk_cmd(REQ_READ, i));
        drain();

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hdl/ugrs_pkg.sv
hdl/ugrs_arith.sv
hdl/ugrs_cnt.sv
hdl/uniform_grid_ray_step_histogram.sv
tb/tb_uniform_grid_ray_step_histogram.sv
